// File: hw/rtl/running_mean_variance_normalizer_unit_macros.svh
// Assertion macros shared by the RTL modules of the normalizer.
// They sample on clk_i and are disabled while rst_ni is low.
`ifndef RUNNING_MEAN_VARIANCE_NORMALIZER_UNIT_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_NORMALIZER_UNIT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define RMVN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge out of reset.
`define RMVN_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/rmvn_pkg.sv
`default_nettype none

package rmvn_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned MEAN_FRAC = 16;
  localparam int unsigned M2_W      = 64;
  localparam int unsigned SQRT_W    = 32;
  localparam int unsigned Z_W       = 24;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned ITER_W    = 7;

  localparam logic FUNC_TRACK = 1'b0;
  localparam logic FUNC_NORM  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_MUL_INIT,
    ST_MUL,
    ST_ACC,
    ST_DIV_VAR,
    ST_SQRT,
    ST_Z_START,
    ST_DIV_Z,
    ST_OUT
  } rmvn_state_e;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/running_mean_variance_normalizer_unit.sv
// Channel   Direction  Handshake                  Payload
// in        request    in_valid_i / in_ready_o    func_i, sample_i
// out       result     out_valid_o / out_ready_i  zscore_o
//
// A track request runs one bit-serial division of the deviation by the count,
// then a shift-add multiply whose product is added to the sum of squares.
// A normalize request runs a 64-step division of the squared deviation sum,
// a 32-step square root and a 48-step division; both divisions share the
// restoring divider, and the square root takes one root step per cycle.
// Reset clears the count, mean and sum of squares; no clearing pass is needed.
// in_ready_o is high only while the sequencer is idle; a finished result waits
// in the output register and does not stop the next request from entering.
`default_nettype none

`include "running_mean_variance_normalizer_unit_macros.svh"

module running_mean_variance_normalizer_unit #(
  parameter int unsigned SAMPLE_FRAC_BITS = 8,
  parameter int unsigned COUNT_WIDTH      = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic [rmvn_pkg::SAMPLE_W-1:0]       sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rmvn_pkg::Z_W-1:0]     zscore_o
);
  import rmvn_pkg::*;

  localparam int unsigned MW    = MEAN_FRAC + SAMPLE_W - SAMPLE_FRAC_BITS;
  localparam int unsigned XSH   = MEAN_FRAC - SAMPLE_FRAC_BITS;
  localparam int unsigned PW    = 2 * MW;
  localparam int unsigned SH    = 2 * MEAN_FRAC - 2 * SAMPLE_FRAC_BITS;
  localparam int unsigned NUM_W = MW + SAMPLE_FRAC_BITS;
  localparam int unsigned VW    = (COUNT_WIDTH > SQRT_W) ? COUNT_WIDTH : SQRT_W;

  rmvn_state_e state_q, state_d;

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [MW-1:0]          mean_q, mean_d;
  logic [M2_W-1:0]        m2_q, m2_d;
  logic [ITER_W-1:0]      iter_q, iter_d;
  logic                   out_valid_q, out_valid_d;

  logic [MW-1:0]          xq_q, xq_d;
  logic [MW-1:0]          d1_q, d1_d;
  logic                   up_q, up_d;
  logic [PW-1:0]          prod_q, prod_d;
  logic [M2_W-1:0]        sv_q, sv_d;
  logic [M2_W-1:0]        res_q, res_d;
  logic [M2_W-1:0]        sq_bit_q, sq_bit_d;
  logic [Z_W-1:0]         zres_q, zres_d;
  logic [Z_W-1:0]         out_z_q, out_z_d;

  logic                   accept;
  logic                   out_free;
  logic [MW-1:0]          xq_in;
  logic                   up_in;
  logic [MW-1:0]          d1_in;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   enough;

  div_req_t               div_req;
  logic [DIV_W-1:0]       div_dividend;
  logic [VW-1:0]          div_divisor;
  logic                   div_done;
  logic [DIV_W-1:0]       quot;

  logic [MW-1:0]          q_mean;
  logic [MW-1:0]          mean_upd;
  logic [MW-1:0]          d2;
  logic [MW:0]            mul_sum;
  logic [PW-1:0]          prod_step;
  logic [M2_W-1:0]        inc;
  logic [M2_W:0]          acc;
  logic [M2_W-1:0]        m2_sat;
  logic [M2_W-1:0]        sq_sum;
  logic                   sq_ge;
  logic [NUM_W-1:0]       zq;
  logic                   z_big;
  logic [Z_W-1:0]         z_sat;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign xq_in     = MW'(sample_i) << XSH;
  assign up_in     = xq_in >= mean_q;
  assign d1_in     = up_in ? xq_in - mean_q : mean_q - xq_in;
  assign count_inc = (&count_q) ? count_q : count_q + COUNT_WIDTH'(1);
  assign enough    = count_q[COUNT_WIDTH-1:1] != '0;

  assign q_mean   = quot[MW-1:0];
  assign mean_upd = up_q ? mean_q + q_mean : mean_q - q_mean;
  // The new mean never crosses the sample, so the sign of d1 still applies.
  assign d2       = up_q ? xq_q - mean_q : mean_q - xq_q;

  // Shift-add multiply, one multiplier bit per cycle from the low end.
  assign mul_sum   = {1'b0, prod_q[PW-1:MW]} + (prod_q[0] ? {1'b0, d1_q} : '0);
  assign prod_step = {mul_sum, prod_q[MW-1:1]};

  assign inc    = prod_q[SH +: M2_W];
  assign acc    = {1'b0, m2_q} + {1'b0, inc};
  assign m2_sat = acc[M2_W] ? '1 : acc[M2_W-1:0];

  assign sq_sum = res_q + sq_bit_q;
  assign sq_ge  = sv_q >= sq_sum;

  // Exactly 2^23 on the negative side maps to the same code as saturation.
  assign zq    = quot[NUM_W-1:0];
  assign z_big = (zq[NUM_W-1:Z_W] != '0) || zq[Z_W-1];
  always_comb begin
    if (up_q) begin
      z_sat = z_big ? {1'b0, {(Z_W-1){1'b1}}} : zq[Z_W-1:0];
    end else begin
      z_sat = z_big ? {1'b1, {(Z_W-1){1'b0}}} : Z_W'(0) - zq[Z_W-1:0];
    end
  end

  rmvn_div #(
    .DIVISOR_W(VW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_TRACK) begin
            state_d = ST_DIV_MEAN;
          end else if (enough) begin
            state_d = ST_DIV_VAR;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) state_d = ST_MUL_INIT;
      end
      ST_MUL_INIT: state_d = ST_MUL;
      ST_MUL: begin
        if (iter_q == ITER_W'(1)) state_d = ST_ACC;
      end
      ST_ACC: state_d = ST_IDLE;
      ST_DIV_VAR: begin
        if (div_done) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (iter_q == ITER_W'(1)) state_d = ST_Z_START;
      end
      ST_Z_START: state_d = (res_q == '0) ? ST_OUT : ST_DIV_Z;
      ST_DIV_Z: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d      = count_q;
    mean_d       = mean_q;
    m2_d         = m2_q;
    iter_d       = iter_q;
    xq_d         = xq_q;
    d1_d         = d1_q;
    up_d         = up_q;
    prod_d       = prod_q;
    sv_d         = sv_q;
    res_d        = res_q;
    sq_bit_d     = sq_bit_q;
    zres_d       = zres_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_z_d      = out_z_q;
    div_req      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          xq_d = xq_in;
          up_d = up_in;
          d1_d = d1_in;
          if (func_i == FUNC_TRACK) begin
            count_d       = count_inc;
            div_req.start = 1'b1;
            div_req.iters = ITER_W'(MW);
            div_dividend  = DIV_W'(d1_in) << (DIV_W - MW);
            div_divisor   = VW'(count_inc);
          end else if (enough) begin
            div_req.start = 1'b1;
            div_req.iters = ITER_W'(DIV_W);
            div_dividend  = m2_q;
            div_divisor   = VW'(count_q - COUNT_WIDTH'(1));
          end else begin
            zres_d = '0;
          end
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) mean_d = mean_upd;
      end
      ST_MUL_INIT: begin
        prod_d = PW'(d2);
        iter_d = ITER_W'(MW);
      end
      ST_MUL: begin
        prod_d = prod_step;
        iter_d = iter_q - ITER_W'(1);
      end
      ST_ACC: m2_d = m2_sat;
      ST_DIV_VAR: begin
        if (div_done) begin
          sv_d     = quot;
          res_d    = '0;
          sq_bit_d = M2_W'(1) << (M2_W - 2);
          iter_d   = ITER_W'(SQRT_W);
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sv_d  = sv_q - sq_sum;
          res_d = (res_q >> 1) + sq_bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        iter_d   = iter_q - ITER_W'(1);
      end
      ST_Z_START: begin
        if (res_q == '0) begin
          zres_d = '0;
        end else begin
          // The deviation scaled by the sample fraction, left-aligned.
          div_req.start = 1'b1;
          div_req.iters = ITER_W'(NUM_W);
          div_dividend  = DIV_W'(d1_q) << (DIV_W - MW);
          div_divisor   = VW'(res_q[SQRT_W-1:0]);
        end
      end
      ST_DIV_Z: begin
        if (div_done) zres_d = z_sat;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_z_d     = zres_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      mean_q      <= mean_d;
      m2_q        <= m2_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xq_q     <= xq_d;
    d1_q     <= d1_d;
    up_q     <= up_d;
    prod_q   <= prod_d;
    sv_q     <= sv_d;
    res_q    <= res_d;
    sq_bit_q <= sq_bit_d;
    zres_q   <= zres_d;
    out_z_q  <= out_z_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign zscore_o    = out_z_q;

  `RMVN_ASSERT(a_track_no_result, (accept && func_i == FUNC_TRACK) |=> out_valid_o == $past(out_valid_o && !out_ready_i), "track request produced a result")
  `RMVN_ASSERT(a_m2_monotonic, m2_q >= $past(m2_q), "sum of squares decreased")
  `RMVN_ASSERT(a_count_monotonic, count_q >= $past(count_q), "sample count decreased")
  `RMVN_ASSERT(a_mean_needs_count, mean_q != '0 |-> count_q != '0, "mean moved without samples")

endmodule

`default_nettype wire

// File: hw/rtl/rmvn_div.sv
`default_nettype none

`include "running_mean_variance_normalizer_unit_macros.svh"

module rmvn_div #(
  parameter int unsigned DIVISOR_W = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rmvn_pkg::div_req_t           req_i,
  input  logic [rmvn_pkg::DIV_W-1:0]   dividend_i,
  input  logic [DIVISOR_W-1:0]         divisor_i,
  output logic                         done_o,
  output logic [rmvn_pkg::DIV_W-1:0]   quot_o
);
  import rmvn_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [ITER_W-1:0]    cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [DIV_W-1:0]     dq_q, dq_d;

  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  // Restoring division, one quotient bit per cycle. The dividend arrives
  // left-aligned, so after the requested number of steps the shift register
  // holds exactly the quotient.
  assign shifted = {rem_q, dq_q[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = !diff[DIVISOR_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dq_d   = dq_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      rem_d  = '0;
      dvs_d  = divisor_i;
      dq_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      dq_d  = {dq_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - ITER_W'(1);
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dq_q  <= dq_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

  `RMVN_NEVER(a_no_start_when_busy, req_i.start && busy_q, "divider started while busy")
  `RMVN_ASSERT(a_busy_has_steps, busy_q |-> cnt_q != '0, "divider busy with no steps left")
  `RMVN_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "divider done without a run")

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import rmvn_pkg::*;

  localparam int unsigned SFB            = 8;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned M2_SHIFT       = 32 - 2 * SFB;
  localparam logic [63:0] COUNT_MAX      = (64'd1 << CNT_W) - 64'd1;
  localparam logic [63:0] Z_POS_MAX      = 64'd8388607;
  localparam logic [63:0] Z_NEG_MAG      = 64'd8388608;
  localparam logic [31:0] CENTER         = 32'd256000;
  localparam int unsigned LIMIT_CYCLES   = 3_000_000;
  localparam int unsigned RX_HOLD_CYCLES = 800;
  localparam int unsigned TAIL_CYCLES    = 200;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  func_i      = FUNC_TRACK;
  logic [SAMPLE_W-1:0]   sample_i    = '0;
  logic                  out_ready_i = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic signed [Z_W-1:0] zscore_o;

  // Statistics as the block should hold them after every accepted request.
  logic [63:0] stat_count = '0;
  logic [63:0] stat_mean  = '0;
  logic [63:0] stat_m2    = '0;

  logic [Z_W-1:0] expected_zscores[$];
  logic [Z_W-1:0] next_zscore;
  int             error_count    = 0;
  int unsigned    cycle_count    = 0;
  int             send_idle_pct  = 0;
  int             recv_idle_pct  = 0;
  logic           rx_hold        = 1'b0;

  running_mean_variance_normalizer_unit #(
    .SAMPLE_FRAC_BITS(SFB),
    .COUNT_WIDTH     (CNT_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .zscore_o   (zscore_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if (cand * cand <= v) root = cand;
    end
    return root[31:0];
  endfunction

  task automatic apply_request(input logic func, input logic [31:0] smp);
    logic [63:0]  xq, d1, d2, var_q, sd, dev, mag, neg_z;
    logic [127:0] prod, inc;
    logic [64:0]  sum;
    logic         up, neg;
    logic [Z_W-1:0] z;
    xq = {32'd0, smp} << (MEAN_FRAC - SFB);
    if (func == FUNC_TRACK) begin
      up = (xq >= stat_mean);
      d1 = up ? xq - stat_mean : stat_mean - xq;
      if (stat_count < COUNT_MAX) stat_count = stat_count + 64'd1;
      if (up) stat_mean = stat_mean + d1 / stat_count;
      else stat_mean = stat_mean - d1 / stat_count;
      d2 = up ? xq - stat_mean : stat_mean - xq;
      prod = {64'd0, d1} * {64'd0, d2};
      inc = prod >> M2_SHIFT;
      sum = {1'b0, stat_m2} + {1'b0, inc[63:0]};
      if (inc[127:64] != '0 || sum[64]) stat_m2 = '1;
      else stat_m2 = sum[63:0];
    end else begin
      z = '0;
      if (stat_count >= 64'd2) begin
        var_q = stat_m2 / (stat_count - 64'd1);
        sd = {32'd0, floor_sqrt(var_q)};
        if (sd != '0) begin
          neg = (xq < stat_mean);
          dev = neg ? stat_mean - xq : xq - stat_mean;
          mag = (dev << SFB) / sd;
          if (neg) begin
            if (mag > Z_NEG_MAG) mag = Z_NEG_MAG;
            neg_z = 64'd0 - mag;
            z = neg_z[Z_W-1:0];
          end else begin
            z = (mag > Z_POS_MAX) ? Z_POS_MAX[Z_W-1:0] : mag[Z_W-1:0];
          end
        end
      end
      expected_zscores.push_back(z);
    end
  endtask

  // Returns at the edge at which the request was accepted.
  task automatic send_request(input logic func, input logic [31:0] smp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    sample_i   <= smp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_request(func, smp);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_zscores.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_too_few_samples();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    send_request(FUNC_NORM, 32'd0);
    send_request(FUNC_NORM, 32'hFFFF_FFFF);
    send_request(FUNC_TRACK, CENTER);
    send_request(FUNC_NORM, CENTER + 32'd256);
    wait_for_results();
  endtask

  task automatic test_zero_spread();
    send_request(FUNC_TRACK, CENTER);
    send_request(FUNC_TRACK, CENTER);
    send_request(FUNC_NORM, CENTER + 32'd1000);
    send_request(FUNC_NORM, 32'd0);
    // A one-LSB step still truncates to no growth in the sum of squares.
    send_request(FUNC_TRACK, CENTER + 32'd1);
    send_request(FUNC_NORM, 32'hFFFF_FFFF);
    wait_for_results();
  endtask

  task automatic test_saturation();
    send_request(FUNC_TRACK, CENTER + 32'd512);
    send_request(FUNC_TRACK, CENTER - 32'd512);
    send_request(FUNC_TRACK, CENTER + 32'd256);
    send_request(FUNC_NORM, 32'hFFFF_FFFF);
    send_request(FUNC_NORM, 32'd0);
    send_request(FUNC_NORM, CENTER + 32'd300);
    send_request(FUNC_NORM, CENTER - 32'd300);
    send_request(FUNC_NORM, CENTER);
    wait_for_results();
  endtask

  // Tracks stay in a cluster around CENTER so that the spread stays small
  // and the z-scores cover the whole output range.
  task automatic test_random_traffic(input int unsigned n_items, input int sp, input int rp);
    logic [31:0] w;
    logic [31:0] smp;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 60) begin
        if ($urandom_range(0, 9) == 0) w = 32'd1 << $urandom_range(11, 16);
        else w = 32'd1 << $urandom_range(0, 10);
        smp = CENTER - w + $urandom_range(0, 2 * w);
        send_request(FUNC_TRACK, smp);
      end else begin
        case ($urandom_range(0, 3))
          0: smp = $urandom;
          1, 2: begin
            w = 32'd1 << $urandom_range(0, 20);
            smp = CENTER - w + $urandom_range(0, 2 * w);
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       smp = 32'd0;
              1:       smp = 32'hFFFF_FFFF;
              2:       smp = CENTER;
              default: smp = 32'd1;
            endcase
          end
        endcase
        send_request(FUNC_NORM, smp);
      end
    end
    wait_for_results();
  endtask

  // The receiver stops long enough that a result parks in the output register
  // and the next normalize request backs up into the input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (10) send_request(FUNC_NORM, CENTER - 32'd2048 + $urandom_range(0, 4096));
    wait_for_results();
  endtask

  // Runs last: once the sum of squares saturates it never comes back down.
  task automatic test_sum_overflow();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    repeat (3) begin
      send_request(FUNC_TRACK, 32'hFFFF_FFFF);
      send_request(FUNC_TRACK, 32'd0);
    end
    send_request(FUNC_NORM, 32'hFFFF_FFFF);
    send_request(FUNC_NORM, 32'd0);
    send_request(FUNC_NORM, CENTER);
    wait_for_results();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_zscores.size() == 0) begin
        $display("%0t: result with no request waiting, actual zscore %0d",
                 $time, $signed(zscore_o));
        error_count++;
      end else begin
        next_zscore = expected_zscores.pop_front();
        if (zscore_o !== next_zscore) begin
          $display("%0t: zscore mismatch, expected %0d actual %0d",
                   $time, $signed(next_zscore), $signed(zscore_o));
          error_count++;
        end
      end
    end
    out_ready_i <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_too_few_samples();
    test_zero_spread();
    test_saturation();
    test_random_traffic(550, 27, 72);
    test_random_traffic(550, 72, 27);
    test_random_traffic(550, 0, 0);
    test_output_backpressure();
    test_sum_overflow();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
